### design/xcrc_pkg.sv
// shared types and constants for the xmodem crc receiver
package xcrc_pkg;

   typedef enum logic [2:0] {
      PH_START     = 3'd0,
      PH_BLOCK     = 3'd1,
      PH_BLOCK_INV = 3'd2,
      PH_DATA      = 3'd3,
      PH_CRC_HI    = 3'd4,
      PH_CRC_LO    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      RPL_NONE = 2'd0,
      RPL_ACK  = 2'd1,
      RPL_NAK  = 2'd2
   } reply_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_WORK = 2'd1,
      ST_DONE = 2'd2,
      ST_CAN  = 2'd3
   } status_type;

   localparam logic [16:0] PAGE_SIZE_RESET = 17'd2048;
   localparam logic [16:0] PAGE_SIZE_MAX   = 17'd65536;

   typedef struct packed {
      reply_type   reply;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [9:0]  data_index;
      logic        packet_commit;
      logic [10:0] commit_length;
      logic [15:0] write_offset;
      logic        page_flush;
      status_type  transfer_status;
      phase_type   phase_now;
   } result_type;

endpackage

### design/xcrc_channels.sv
// valid/ready channel interfaces for received bytes and result transactions
interface xcrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reply;
   logic        data_valid;
   logic [7:0]  data_byte;
   logic [9:0]  data_index;
   logic        packet_commit;
   logic [10:0] commit_length;
   logic [15:0] write_offset;
   logic        page_flush;
   logic [1:0]  transfer_status;
   logic [2:0]  phase_now;

   modport source (
      output valid, output reply, output data_valid, output data_byte,
      output data_index, output packet_commit, output commit_length,
      output write_offset, output page_flush, output transfer_status,
      output phase_now, input ready
   );
   modport sink (
      input valid, input reply, input data_valid, input data_byte,
      input data_index, input packet_commit, input commit_length,
      input write_offset, input page_flush, input transfer_status,
      input phase_now, output ready
   );
endinterface

### design/xcrc_crc_byte.sv
// crc-16/xmodem update over one byte, eight shift steps unrolled
module xcrc_crc_byte (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data,
   output logic [15:0] crc_nxt
);

   localparam logic [15:0] CRC_POLY = 16'h1021;

   always_comb begin
      logic [15:0] c;
      c = crc_cur ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_nxt = c;
   end

endmodule

### design/xcrc_engine.sv
// packet phase tracking, sequence check and page fill bookkeeping
module xcrc_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   input  logic [16:0]         page_size,
   output xcrc_pkg::result_type result
);

   localparam logic [7:0]  CODE_SOH     = 8'h01;
   localparam logic [7:0]  CODE_STX     = 8'h02;
   localparam logic [7:0]  CODE_EOT     = 8'h04;
   localparam logic [7:0]  CODE_CAN     = 8'h18;
   localparam logic [10:0] SMALL_PACKET = 11'd128;
   localparam logic [10:0] MAX_PACKET   = 11'd1024;

   xcrc_pkg::phase_type  phase_ff, phase_in;
   xcrc_pkg::status_type status_ff, status_in;
   logic [10:0] packet_length_ff, packet_length_in;
   logic [7:0]  block_number_ff, block_number_in;
   logic [7:0]  expected_block_ff, expected_block_in;
   logic [10:0] byte_count_ff, byte_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic [16:0] page_fill_ff, page_fill_in;

   logic [15:0] crc_upd;
   logic [10:0] count_inc;
   logic [17:0] fill_sum;
   logic        no_fit;
   logic [16:0] fill_base;

   xcrc_crc_byte u_crc (
      .crc_cur (crc_ff),
      .data    (rx_byte),
      .crc_nxt (crc_upd)
   );

   assign count_inc = byte_count_ff + 11'd1;
   assign fill_sum  = {1'b0, page_fill_ff} + {7'd0, packet_length_ff};
   assign no_fit    = fill_sum > {1'b0, page_size};
   assign fill_base = no_fit ? 17'd0 : page_fill_ff;

   always_comb begin
      phase_in          = phase_ff;
      status_in         = status_ff;
      packet_length_in  = packet_length_ff;
      block_number_in   = block_number_ff;
      expected_block_in = expected_block_ff;
      byte_count_in     = byte_count_ff;
      crc_in            = crc_ff;
      crc_high_in       = crc_high_ff;
      page_fill_in      = page_fill_ff;

      result               = '0;
      result.reply         = xcrc_pkg::RPL_NONE;

      unique case (phase_ff)
         xcrc_pkg::PH_START: begin
            if (rx_byte == CODE_SOH || rx_byte == CODE_STX) begin
               packet_length_in = (rx_byte == CODE_SOH) ? SMALL_PACKET : MAX_PACKET;
               phase_in  = xcrc_pkg::PH_BLOCK;
               status_in = xcrc_pkg::ST_WORK;
            end else if (rx_byte == CODE_EOT) begin
               result.reply = xcrc_pkg::RPL_ACK;
               if (page_fill_ff != 17'd0) begin
                  result.page_flush = 1'b1;
                  page_fill_in      = 17'd0;
               end
               status_in = xcrc_pkg::ST_DONE;
            end else if (rx_byte == CODE_CAN) begin
               status_in = xcrc_pkg::ST_CAN;
            end else begin
               status_in = xcrc_pkg::ST_IDLE;
            end
         end
         xcrc_pkg::PH_BLOCK: begin
            block_number_in = rx_byte;
            phase_in        = xcrc_pkg::PH_BLOCK_INV;
         end
         xcrc_pkg::PH_BLOCK_INV: begin
            if ((block_number_ff + rx_byte) != 8'hFF) begin
               result.reply = xcrc_pkg::RPL_NAK;
               phase_in     = xcrc_pkg::PH_START;
            end else begin
               byte_count_in = 11'd0;
               crc_in        = 16'd0;
               phase_in      = xcrc_pkg::PH_DATA;
            end
         end
         xcrc_pkg::PH_DATA: begin
            result.data_valid = 1'b1;
            result.data_byte  = rx_byte;
            result.data_index = byte_count_ff[9:0];
            crc_in            = crc_upd;
            byte_count_in     = count_inc;
            if (count_inc >= packet_length_ff || count_inc >= MAX_PACKET) begin
               phase_in = xcrc_pkg::PH_CRC_HI;
            end
         end
         xcrc_pkg::PH_CRC_HI: begin
            crc_high_in = rx_byte;
            phase_in    = xcrc_pkg::PH_CRC_LO;
         end
         xcrc_pkg::PH_CRC_LO: begin
            if ({crc_high_ff, rx_byte} == crc_ff) begin
               if (block_number_ff == expected_block_ff) begin
                  // in-order packet: flush first if it overflows the page
                  result.page_flush    = no_fit;
                  result.packet_commit = 1'b1;
                  result.commit_length = packet_length_ff;
                  result.write_offset  = fill_base[15:0];
                  page_fill_in         = fill_base + {6'd0, packet_length_ff};
                  expected_block_in    = expected_block_ff + 8'd1;
                  result.reply         = xcrc_pkg::RPL_ACK;
               end else if (block_number_ff == expected_block_ff - 8'd1) begin
                  result.reply = xcrc_pkg::RPL_ACK;
               end else begin
                  result.reply = xcrc_pkg::RPL_NAK;
               end
            end else begin
               result.reply = xcrc_pkg::RPL_NAK;
            end
            phase_in = xcrc_pkg::PH_START;
         end
         default: begin
            phase_in = xcrc_pkg::PH_START;
         end
      endcase

      result.transfer_status = status_in;
      result.phase_now       = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= xcrc_pkg::PH_START;
         status_ff         <= xcrc_pkg::ST_IDLE;
         packet_length_ff  <= 11'd0;
         block_number_ff   <= 8'd0;
         expected_block_ff <= 8'd1;
         byte_count_ff     <= 11'd0;
         crc_ff            <= 16'd0;
         crc_high_ff       <= 8'd0;
         page_fill_ff      <= 17'd0;
      end else if (step) begin
         phase_ff          <= phase_in;
         status_ff         <= status_in;
         packet_length_ff  <= packet_length_in;
         block_number_ff   <= block_number_in;
         expected_block_ff <= expected_block_in;
         byte_count_ff     <= byte_count_in;
         crc_ff            <= crc_in;
         crc_high_ff       <= crc_high_in;
         page_fill_ff      <= page_fill_in;
      end
   end

endmodule

### design/xmodem_crc_receiver_top.sv
// top level of the xmodem-1k crc receiver: input register, engine, result register
//
//   channel | dir | handshake      | payload
//   --------+-----+----------------+--------------------------------------------
//   req     | in  | valid / ready  | rx_byte
//   rsp     | out | valid / ready  | reply, data fields, commit fields, status
//   csr     | in  | csr_we         | csr_wdata = page_size, clamped to 65536
//
// one transaction per cycle sustained while rsp does not stall; a byte waits in the
// input register, and its result is captured in the result register
// every received byte yields exactly one result transaction
// reset (synchronous, active high) empties both registers and restores state
// a stalled rsp holds the result register; the input register still refills
// once its byte has moved on, so req stalls only when both are occupied
module xmodem_crc_receiver_top (
   input  logic        clock,
   input  logic        reset,
   xcrc_req_if.sink    req,
   xcrc_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);

   // page size register, out-of-range writes saturate
   logic [16:0] page_size_ff, page_size_in;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // result register
   logic                 out_valid_ff;
   xcrc_pkg::result_type out_ff;
   xcrc_pkg::result_type result;

   logic advance;
   logic step;

   assign page_size_in = (csr_wdata > xcrc_pkg::PAGE_SIZE_MAX) ?
                         xcrc_pkg::PAGE_SIZE_MAX : csr_wdata;

   // result register free or being drained this cycle
   assign advance   = !out_valid_ff || rsp.ready;
   assign step      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;

   xcrc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .page_size (page_size_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= xcrc_pkg::PAGE_SIZE_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            page_size_ff <= page_size_in;
         end
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.rx_byte;
      end
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.reply           = out_ff.reply;
   assign rsp.data_valid      = out_ff.data_valid;
   assign rsp.data_byte       = out_ff.data_byte;
   assign rsp.data_index      = out_ff.data_index;
   assign rsp.packet_commit   = out_ff.packet_commit;
   assign rsp.commit_length   = out_ff.commit_length;
   assign rsp.write_offset    = out_ff.write_offset;
   assign rsp.page_flush      = out_ff.page_flush;
   assign rsp.transfer_status = out_ff.transfer_status;
   assign rsp.phase_now       = out_ff.phase_now;

endmodule

### verif/xcrc_tb_pkg.sv
// start codes and crc-16/xmodem byte update shared by the stimulus and the checker
package xcrc_tb_pkg;

   localparam logic [7:0] CODE_SOH = 8'h01;
   localparam logic [7:0] CODE_STX = 8'h02;
   localparam logic [7:0] CODE_EOT = 8'h04;
   localparam logic [7:0] CODE_CAN = 8'h18;

   localparam logic [10:0] SHORT_PACKET_LEN = 11'd128;
   localparam logic [10:0] LONG_PACKET_LEN  = 11'd1024;

   // poly 0x1021, msb first, no reflection
   function automatic logic [15:0] crc16_xmodem(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
   endfunction

endpackage

### verif/xcrc_checker.sv
// checker for the xmodem crc receiver: predicts each result transaction and compares it
module xcrc_checker (
   input  logic        clock,
   input  logic        reset,
   xcrc_req_if         req_mon,
   xcrc_rsp_if         rsp_mon,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata,
   output int          failures,
   output int          pending,
   output int          checked,
   output int          commits,
   output int          flushes,
   output int          naks
);
   import xcrc_pkg::*;
   import xcrc_tb_pkg::*;

   // receiver state as the predictor sees it
   logic [16:0] page_size;
   phase_type   rx_phase;
   logic [10:0] pkt_len;
   logic [7:0]  blk_num;
   logic [7:0]  next_blk;
   logic [10:0] nbytes;
   logic [15:0] crc_acc;
   logic [7:0]  crc_hi;
   logic [16:0] fill;
   status_type  xfer_status;

   result_type awaited_results[$];

   task automatic report_mismatch(input string msg);
      failures++;
      if (failures <= 40)
         $display("[%0t] mismatch at result %0d: %s", $time, checked, msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   function automatic result_type receive_byte(input logic [7:0] b);
      result_type r;
      r = '0;
      case (rx_phase)
         PH_START: begin
            if (b == CODE_SOH || b == CODE_STX) begin
               pkt_len = (b == CODE_SOH) ? SHORT_PACKET_LEN : LONG_PACKET_LEN;
               rx_phase = PH_BLOCK;
               xfer_status = ST_WORK;
            end else if (b == CODE_EOT) begin
               r.reply = RPL_ACK;
               if (fill != 0) begin
                  r.page_flush = 1'b1;
                  fill = '0;
               end
               xfer_status = ST_DONE;
            end else if (b == CODE_CAN) begin
               xfer_status = ST_CAN;
            end else begin
               xfer_status = ST_IDLE;
            end
         end
         PH_BLOCK: begin
            blk_num = b;
            rx_phase = PH_BLOCK_INV;
         end
         PH_BLOCK_INV: begin
            if (8'(blk_num + b) != 8'hFF) begin
               r.reply = RPL_NAK;
               rx_phase = PH_START;
            end else begin
               nbytes = '0;
               crc_acc = '0;
               rx_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            r.data_valid = 1'b1;
            r.data_byte = b;
            r.data_index = nbytes[9:0];
            crc_acc = crc16_xmodem(crc_acc, b);
            nbytes = nbytes + 11'd1;
            if (nbytes >= pkt_len || nbytes >= LONG_PACKET_LEN)
               rx_phase = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            crc_hi = b;
            rx_phase = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            if ({crc_hi, b} == crc_acc) begin
               if (blk_num == next_blk) begin
                  // packet that would overrun the page forces a flush first
                  if (int'(fill) + int'(pkt_len) > int'(page_size)) begin
                     r.page_flush = 1'b1;
                     fill = '0;
                  end
                  r.packet_commit = 1'b1;
                  r.commit_length = pkt_len;
                  r.write_offset = fill[15:0];
                  fill = fill + 17'(pkt_len);
                  next_blk = next_blk + 8'd1;
                  r.reply = RPL_ACK;
               end else if (blk_num == 8'(next_blk - 8'd1)) begin
                  r.reply = RPL_ACK;
               end else begin
                  r.reply = RPL_NAK;
               end
            end else begin
               r.reply = RPL_NAK;
            end
            rx_phase = PH_START;
         end
         default: rx_phase = PH_START;
      endcase
      r.transfer_status = xfer_status;
      r.phase_now = rx_phase;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         page_size = PAGE_SIZE_RESET;
         rx_phase = PH_START;
         pkt_len = '0;
         blk_num = '0;
         next_blk = 8'd1;
         nbytes = '0;
         crc_acc = '0;
         crc_hi = '0;
         fill = '0;
         xfer_status = ST_IDLE;
         awaited_results.delete();
      end else begin
         if (csr_we)
            page_size = (csr_wdata > PAGE_SIZE_MAX) ? PAGE_SIZE_MAX : csr_wdata;
         // result side first: a byte accepted at this edge cannot answer at the same edge
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result transaction with nothing expected");
            end else begin
               want = awaited_results.pop_front();
               compare_field("reply", rsp_mon.reply, want.reply);
               compare_field("data_valid", rsp_mon.data_valid, want.data_valid);
               compare_field("data_byte", rsp_mon.data_byte, want.data_byte);
               compare_field("data_index", rsp_mon.data_index, want.data_index);
               compare_field("packet_commit", rsp_mon.packet_commit, want.packet_commit);
               compare_field("commit_length", rsp_mon.commit_length, want.commit_length);
               compare_field("write_offset", rsp_mon.write_offset, want.write_offset);
               compare_field("page_flush", rsp_mon.page_flush, want.page_flush);
               compare_field("transfer_status", rsp_mon.transfer_status,
                             want.transfer_status);
               compare_field("phase_now", rsp_mon.phase_now, want.phase_now);
               checked++;
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            want = receive_byte(req_mon.rx_byte);
            if (want.packet_commit) commits++;
            if (want.page_flush) flushes++;
            if (want.reply == RPL_NAK) naks++;
            awaited_results.push_back(want);
         end
      end
      pending = awaited_results.size();
   end

endmodule

### verif/testbench.sv
// top of the xmodem crc receiver testbench: clock, reset, byte stimulus, stalls and verdict
module testbench;
   import xcrc_pkg::*;
   import xcrc_tb_pkg::*;

   // bytes of mixed random traffic per page size setting
   localparam int PHASE_ITEMS = 40;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [16:0] csr_wdata;

   xcrc_req_if req_ch ();
   xcrc_rsp_if rsp_ch ();

   int failures;
   int pending;
   int checked;
   int commits;
   int flushes;
   int naks;

   int          bytes_sent;
   int          burst_left;
   int          settings_used;
   logic [7:0]  next_blk;       // block number the receiver should take next
   logic [16:0] page_sizes [4];

   xmodem_crc_receiver_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   xcrc_checker rx_check (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_ch),
      .rsp_mon   (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending),
      .checked   (checked),
      .commits   (commits),
      .flushes   (flushes),
      .naks      (naks)
   );

   // period of 4 time units
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // hard stop in case the handshakes hang
   initial begin
      #2000000;
      $display("timeout: run did not finish in time");
      $display("Test completed with failures");
      $finish;
   end

   // receiver stalls: each stretch picks a pattern and keeps it for a while
   initial begin
      int mode;
      int left;
      int stall;
      mode = 0;
      left = 0;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(50, 300);
         end
         left--;
         case (mode)
            0: rsp_ch.ready <= 1'b1;                        // no back-pressure at all
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));    // coin flip every cycle
            2: begin                                       // mostly ready, rare long stalls
               if (stall > 0) begin
                  stall--;
                  rsp_ch.ready <= 1'b0;
               end else if ($urandom_range(0, 19) == 0) begin
                  stall = $urandom_range(1, 12);
                  rsp_ch.ready <= 1'b0;
               end else begin
                  rsp_ch.ready <= 1'b1;
               end
            end
            default: rsp_ch.ready <= (left % 4 == 0);        // ready only when left is a multiple of four
         endcase
      end
   end

   // offer one byte; valid stays high across a burst and drops only for a gap
   task automatic offer_byte(input logic [7:0] b);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_until_quiet();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_page_size(input logic [16:0] size);
      wait_until_quiet();
      csr_we <= 1'b1;
      csr_wdata <= size;
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // one packet; break_inverse stops after a wrong complement byte
   task automatic send_packet(input logic [7:0] code, input logic [7:0] blk,
                              input bit break_inverse, input bit break_crc);
      int          len;
      int          fill_mode;
      logic [7:0]  d;
      logic [15:0] crc;
      len = (code == CODE_SOH) ? int'(SHORT_PACKET_LEN) : int'(LONG_PACKET_LEN);
      fill_mode = $urandom_range(0, 7);
      offer_byte(code);
      offer_byte(blk);
      if (break_inverse) begin
         offer_byte(~blk ^ 8'($urandom_range(1, 255)));
         return;
      end
      offer_byte(~blk);
      crc = '0;
      for (int i = 0; i < len; i++) begin
         if (fill_mode == 0)
            d = 8'h00;
         else if (fill_mode == 1)
            d = 8'hFF;
         else
            d = 8'($urandom_range(0, 255));
         crc = crc16_xmodem(crc, d);
         offer_byte(d);
      end
      if (break_crc)
         crc = crc ^ 16'($urandom_range(1, 65535));
      offer_byte(crc[15:8]);
      offer_byte(crc[7:0]);
   endtask

   // mixed traffic, mostly well-formed in-order packets
   task automatic random_traffic(input int count);
      int         stop;
      int         pick;
      int         n;
      logic [7:0] b;
      logic [7:0] code;
      stop = bytes_sent + count;
      while (bytes_sent < stop) begin
         pick = $urandom_range(0, 99);
         code = ($urandom_range(0, 1) == 0) ? CODE_SOH : CODE_STX;
         if (pick < 52) begin
            send_packet(CODE_SOH, next_blk, 1'b0, 1'b0);
            next_blk++;
         end else if (pick < 54) begin
            send_packet(CODE_STX, next_blk, 1'b0, 1'b0);
            next_blk++;
         end else if (pick < 62) begin
            // retransmission of the last accepted block
            send_packet(CODE_SOH, next_blk - 8'd1, 1'b0, 1'b0);
         end else if (pick < 70) begin
            // out-of-order block with a good crc
            do b = 8'($urandom_range(0, 255));
            while (b == next_blk || b == 8'(next_blk - 8'd1));
            send_packet(CODE_SOH, b, 1'b0, 1'b0);
         end else if (pick < 78) begin
            send_packet(CODE_SOH, next_blk, 1'b0, 1'b1);
         end else if (pick < 85) begin
            send_packet(code, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
         end else if (pick < 90) begin
            offer_byte(CODE_EOT);
         end else if (pick < 93) begin
            offer_byte(CODE_CAN);
         end else begin
            // line noise that is not a start code
            n = $urandom_range(1, 3);
            repeat (n) begin
               do b = 8'($urandom_range(0, 255));
               while (b == CODE_SOH || b == CODE_STX || b == CODE_EOT || b == CODE_CAN);
               offer_byte(b);
            end
         end
         if ($urandom_range(0, 24) == 0)
            wait_until_quiet();
      end
   endtask

   initial begin
      int waited;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      bytes_sent = 0;
      burst_left = 0;
      settings_used = 0;
      next_blk = 8'd1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: unknown start bytes at both extremes, cancel, end of transfer
      // with an empty page, and bad complements on both packet sizes
      offer_byte(8'h00);
      offer_byte(8'hFF);
      offer_byte(CODE_CAN);
      offer_byte(CODE_EOT);
      offer_byte(CODE_SOH);
      offer_byte(8'h00);
      offer_byte(8'h00);
      offer_byte(CODE_STX);
      offer_byte(8'hFF);
      offer_byte(8'hFF);
      send_packet(CODE_SOH, 8'h01, 1'b1, 1'b0);
      send_packet(CODE_STX, 8'hFE, 1'b1, 1'b0);
      offer_byte(8'h7F);

      // first stretch runs on the page size out of reset
      random_traffic(PHASE_ITEMS);

      page_sizes[0] = 17'd1024;
      page_sizes[1] = PAGE_SIZE_MAX;
      page_sizes[2] = 17'h1FFFF;     // above the maximum, should clamp
      page_sizes[3] = 17'($urandom_range(1025, 65535));
      for (int p = 0; p < 4; p++) begin
         set_page_size(page_sizes[p]);
         if (p == 0) begin
            // fresh page after the write is not guaranteed, so flush with eot first,
            // then a long packet fills the smallest page exactly and a short one overflows it
            offer_byte(CODE_EOT);
            send_packet(CODE_STX, next_blk, 1'b0, 1'b0);
            next_blk++;
            send_packet(CODE_SOH, next_blk, 1'b0, 1'b0);
            next_blk++;
         end
         random_traffic(PHASE_ITEMS);
      end

      // drain with a bound, then allow the pipeline to settle
      @(negedge clock);
      req_ch.valid <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      if (pending != 0) begin
         $display("timeout: %0d result transactions never arrived", pending);
         $display("Test completed with failures");
      end else begin
         repeat (8) @(negedge clock);
         $display("covered %0d bytes, %0d results checked: %0d commits, %0d page flushes, %0d NAKs",
                  bytes_sent, checked, commits, flushes, naks);
         $display("page size settings written: %0d, including 1024, 65536 and a clamped value",
                  settings_used);
         if (failures == 0)
            $display("Test completed successfully");
         else
            $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### xmodem_crc_receiver_top.f
design/xcrc_pkg.sv
design/xcrc_channels.sv
design/xcrc_crc_byte.sv
design/xcrc_engine.sv
design/xmodem_crc_receiver_top.sv
verif/xcrc_tb_pkg.sv
verif/xcrc_checker.sv
verif/testbench.sv
